/* hw/rtl/joystick_direction_qualifier_assert.svh */
// assertion macros for the joystick direction qualifier
`ifndef JOYSTICK_DIRECTION_QUALIFIER_ASSERT_SVH
`define JOYSTICK_DIRECTION_QUALIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that holds at every clock edge outside reset
`define JDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication outside reset
`define JDQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define JDQ_ASSERT(label, prop, msg)
`define JDQ_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/jdq_pkg.sv */
// shared types, register codes and helpers for the joystick direction qualifier
package jdq_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned ThreshW = 16;
	localparam int unsigned CfgIdxW = 2;

	// accepted status codes
	typedef enum logic [3:0] {
		ST_NONE  = 4'd0,
		ST_PUSH  = 4'd1,
		ST_UP    = 4'd2,
		ST_DOWN  = 4'd3,
		ST_LEFT  = 4'd4,
		ST_RIGHT = 4'd5,
		ST_UL    = 4'd6,
		ST_UR    = 4'd7,
		ST_DL    = 4'd8,
		ST_DR    = 4'd9
	} status_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_DECODER_MODE   = 2'd0,
		CFG_PUSH_HOLD_MS   = 2'd1,
		CFG_IDLE_RETURN_MS = 2'd2
	} cfg_idx_t;

	// decoder modes
	localparam logic MODE_PUSH_GATED = 1'b0;

	localparam logic [ThreshW-1:0] PushHoldDefault   = 16'd1000;
	localparam logic [ThreshW-1:0] IdleReturnDefault = 16'd5000;

	// active-high switch levels of one poll
	typedef struct packed {
		logic push;
		logic up;
		logic down;
		logic left;
		logic right;
	} switches_t;

	// wrapped time difference read as signed, negative never exceeds
	function automatic logic exceeds(input logic [TimeW-1:0] diff,
			input logic [ThreshW-1:0] thr);
		return !diff[TimeW-1] &&
			(diff[TimeW-2:0] > {{(TimeW-1-ThreshW){1'b0}}, thr});
	endfunction

endpackage

/* hw/rtl/jdq_decode.sv */
// switch level decoder with two priority schemes
module jdq_decode
	import jdq_pkg::*;
(
	input  switches_t sw,
	input  logic      decoder_mode,
	output status_t   status
);

	status_t dirs;
	status_t fallback;

	always_comb begin
		if (decoder_mode == MODE_PUSH_GATED) begin
			fallback = ST_PUSH;
		end else begin
			fallback = sw.push ? ST_PUSH : ST_NONE;
		end

		// up before down, left before right on diagonals
		if (sw.up) begin
			dirs = sw.left ? ST_UL : (sw.right ? ST_UR : ST_UP);
		end else if (sw.down) begin
			dirs = sw.left ? ST_DL : (sw.right ? ST_DR : ST_DOWN);
		end else if (sw.left) begin
			dirs = ST_LEFT;
		end else if (sw.right) begin
			dirs = ST_RIGHT;
		end else begin
			dirs = fallback;
		end

		if (decoder_mode == MODE_PUSH_GATED && !sw.push) begin
			status = ST_NONE;
		end else begin
			status = dirs;
		end
	end

endmodule

/* hw/rtl/joystick_direction_qualifier.sv */
// top level of the joystick direction qualifier
`include "joystick_direction_qualifier_assert.svh"

// Joystick direction qualifier. Every input beat is one poll of five
// active-low switches (push, up, down, left, right) plus the millisecond
// time of the poll; every poll yields exactly one output beat carrying the
// accepted status, the speed flag and the going-forward flag as they stand
// after that poll. A decoded status is only accepted once two consecutive
// polls agree. Throughput is one poll per clock while out_stall does not hold
// the output beat: a beat is captured in the input register, the decode,
// the 32-bit time difference and the two threshold compares run on it
// combinationally, and the qualifier state registers, which double as the
// output register, load from them. in_stall rises only when the input
// register is full and the output beat is held by out_stall. Configuration
// writes are always ready and take effect on the following poll; write them
// only while no poll is in flight. Register index 0 is decoder_mode, 1
// push_hold_ms, 2 idle_return_ms; index 3 is ignored.
module joystick_direction_qualifier
	import jdq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// poll channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               push_n,
	input  logic               up_n,
	input  logic               down_n,
	input  logic               left_n,
	input  logic               right_n,
	input  logic [TimeW-1:0]   now_ms,

	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         accepted_status,
	output logic               fast_speed,
	output logic               going_forward,

	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ThreshW-1:0] cfg_data
);

	// configuration registers
	logic               decoder_mode_q;
	logic [ThreshW-1:0] push_hold_q;
	logic [ThreshW-1:0] idle_return_q;

	// input register
	logic               valid_s1;
	switches_t          sw_s1;
	logic [TimeW-1:0]   now_s1;

	// qualifier state, also the output register
	logic               out_valid_q;
	status_t            last_q;
	status_t            stable_q;
	logic               speed_q;
	logic               forward_q;
	logic [TimeW-1:0]   chg_time_q;

	// handshake
	logic               out_free;
	logic               fire_s1;
	logic               in_accept;

	// step logic
	status_t            cur;
	logic               same;
	logic               toggle;
	logic               change;
	logic [TimeW-1:0]   diff;
	logic               long_push;
	logic               long_idle;
	logic               speed_nxt;
	logic               forward_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoder_mode_q <= 1'b0;
			push_hold_q    <= PushHoldDefault;
			idle_return_q  <= IdleReturnDefault;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DECODER_MODE:   decoder_mode_q <= cfg_data[0];
				CFG_PUSH_HOLD_MS:   push_hold_q    <= cfg_data;
				CFG_IDLE_RETURN_MS: idle_return_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register frees up when empty or when its beat leaves
	assign out_free  = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture, levels turned active high
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sw_s1.push  <= !push_n;
			sw_s1.up    <= !up_n;
			sw_s1.down  <= !down_n;
			sw_s1.left  <= !left_n;
			sw_s1.right <= !right_n;
			now_s1      <= now_ms;
		end
	end

	jdq_decode u_decode (
		.sw           (sw_s1),
		.decoder_mode (decoder_mode_q),
		.status       (cur)
	);

	// two agreeing polls qualify a status
	assign same   = (last_q == cur);
	assign toggle = same && (cur == ST_PUSH) && (stable_q == ST_PUSH);
	assign change = same && (stable_q != cur);

	// time since the last accepted change, wraps modulo 2^32
	assign diff      = now_s1 - chg_time_q;
	assign long_push = exceeds(diff, push_hold_q);
	assign long_idle = exceeds(diff, idle_return_q);

	always_comb begin
		speed_nxt   = speed_q ^ toggle;
		forward_nxt = forward_q;
		if (change) begin
			// long push released sets forward, any other change clears forward and drops to slow
			if (stable_q == ST_PUSH && cur == ST_NONE && long_push) begin
				forward_nxt = 1'b1;
			end else begin
				forward_nxt = 1'b0;
				speed_nxt   = 1'b0;
			end
			// leaving a long idle also drops to slow
			if (stable_q == ST_NONE && long_idle) begin
				speed_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= ST_NONE;
			stable_q    <= ST_NONE;
			speed_q     <= 1'b0;
			forward_q   <= 1'b0;
			chg_time_q  <= '0;
		end else begin
			if (fire_s1) begin
				out_valid_q <= 1'b1;
				last_q      <= cur;
				speed_q     <= speed_nxt;
				forward_q   <= forward_nxt;
				if (change) begin
					stable_q   <= cur;
					chg_time_q <= now_s1;
				end
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted_status = stable_q;
	assign fast_speed      = speed_q;
	assign going_forward   = forward_q;

	// forward can only stand while the accepted status is none
	`JDQ_ASSERT_IMPL(a_forward_idle, forward_q, stable_q == ST_NONE,
		"going forward set with a status other than none")

	// speed only turns fast while push is the accepted status
	`JDQ_ASSERT_IMPL(a_fast_on_push, $rose(speed_q), stable_q == ST_PUSH,
		"fast speed entered outside a stable push")

	// an accepted change stamps the time of its poll
	`JDQ_ASSERT_IMPL(a_change_stamp, stable_q != $past(stable_q),
		chg_time_q == $past(now_s1), "change time not taken from the qualifying poll")

	// the state only moves when a poll passes into the output register
	`JDQ_ASSERT(a_state_hold, !$past(fire_s1) |-> $stable(last_q) && $stable(speed_q),
		"qualifier state moved without a poll")

	// the input side only stalls while a poll is held
	`JDQ_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall,
		"input stalled without a held poll")

endmodule
